FILE: rtl/core/sia_pkg.sv
`default_nettype none

package sia_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int RD_GROUP       = 8;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  index;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [6:0]  count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic ins;
    logic era;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/sia_cell.sv
`default_nettype none

module sia_cell #(
  parameter int WORD_WIDTH = sia_pkg::WORD_WIDTH_DEF,
  parameter int AW         = 6,
  parameter int POS        = 0
) (
  input  wire                   clk,
  input  sia_pkg::cell_cmd_t    cmd,
  input  wire  [AW-1:0]         addr,
  input  wire  [WORD_WIDTH-1:0] din,
  input  wire  [WORD_WIDTH-1:0] left_data,
  input  wire  [WORD_WIDTH-1:0] right_data,
  output logic [WORD_WIDTH-1:0] data,
  output logic [WORD_WIDTH-1:0] rd_data
);

  localparam logic [AW-1:0] MY_POS = AW'(POS);

  logic [WORD_WIDTH-1:0] data_r;
  logic [WORD_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (MY_POS == addr) begin
        data_nxt = din;
      end else if (MY_POS > addr) begin
        data_nxt = left_data;
      end
    end else if (cmd.era) begin
      if (MY_POS >= addr) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (MY_POS == addr) ? data_r : '0;

endmodule

`default_nettype wire

FILE: rtl/core/sia_rd_tree.sv
`default_nettype none

module sia_rd_tree #(
  parameter int WORD_WIDTH = sia_pkg::WORD_WIDTH_DEF,
  parameter int DEPTH      = sia_pkg::DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   en,
  input  wire  [WORD_WIDTH-1:0] words [DEPTH],
  output logic [WORD_WIDTH-1:0] rd_word
);

  localparam int GRP  = sia_pkg::RD_GROUP;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  logic [WORD_WIDTH-1:0] grp_r   [NGRP];
  logic [WORD_WIDTH-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | words[g*GRP+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/shift_insert_array.sv
// Ordered word array of DEPTH entries held in a chain of cells. Each input word
// carries an opcode (push, pop, insert, erase, get), an index and a value, and
// produces exactly one output word with the read value, the count after the
// operation and a status (ok, full, empty, bad index); a failing operation
// changes nothing. Items are taken one at a time, in order: accept, the
// registered OR tree that reads the addressed cell, then a step in which all
// cells shift at once and the result is registered, which waits while a full
// output is stalled. The output register keeps the result while out_stall is
// high, and the next item is accepted as soon as it is loaded.
// Entries need no clearing after reset; control state and count are reset.
`default_nettype none

module shift_insert_array #(
  parameter int DEPTH      = sia_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = sia_pkg::WORD_WIDTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  sia_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  wire                out_stall,
  output sia_pkg::out_word_t out_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  sia_pkg::state_t state_r;
  sia_pkg::state_t state_nxt;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         newcnt_r;
  logic [CW-1:0]         newcnt_nxt;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         addr_nxt;
  logic [WORD_WIDTH-1:0] val_r;
  logic                  rden_r;
  logic                  rden_nxt;
  logic [1:0]            status_r;
  logic [1:0]            status_nxt;
  sia_pkg::cell_cmd_t    cmd_r;
  sia_pkg::cell_cmd_t    cmd_nxt;
  sia_pkg::cell_cmd_t    cell_cmd;

  logic                  out_valid_r;
  sia_pkg::out_word_t    out_word_r;

  logic                  accept;
  logic                  fire;
  logic                  tree_en;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         cnt_x;
  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;
  logic [15:0]           cnt_ext;

  logic [WORD_WIDTH-1:0] cell_data [DEPTH];
  logic [WORD_WIDTH-1:0] cell_rd   [DEPTH];
  logic [WORD_WIDTH-1:0] rd_word;

  assign accept  = in_valid && !in_stall;
  assign idx_x   = XW'(in_word.index);
  assign cnt_x   = XW'(count_r);
  assign val_ext = 64'(in_word.value);

  // decode against the current count
  always_comb begin
    cmd_nxt    = '0;
    rden_nxt   = 1'b0;
    status_nxt = sia_pkg::ST_OK;
    newcnt_nxt = count_r;
    addr_nxt   = AW'(idx_x);
    case (in_word.opcode)
      sia_pkg::OP_PUSH: begin
        if (count_r == CW'(DEPTH)) begin
          status_nxt = sia_pkg::ST_FULL;
        end else begin
          cmd_nxt.ins = 1'b1;
          addr_nxt    = AW'(count_r);
          newcnt_nxt  = count_r + CW'(1);
        end
      end
      sia_pkg::OP_POP: begin
        if (count_r == '0) begin
          status_nxt = sia_pkg::ST_EMPTY;
        end else begin
          rden_nxt   = 1'b1;
          addr_nxt   = AW'(count_r - CW'(1));
          newcnt_nxt = count_r - CW'(1);
        end
      end
      sia_pkg::OP_INSERT: begin
        if (count_r == CW'(DEPTH)) begin
          status_nxt = sia_pkg::ST_FULL;
        end else if (idx_x > cnt_x) begin
          status_nxt = sia_pkg::ST_BADIDX;
        end else begin
          cmd_nxt.ins = 1'b1;
          newcnt_nxt  = count_r + CW'(1);
        end
      end
      sia_pkg::OP_ERASE: begin
        if (count_r == '0) begin
          status_nxt = sia_pkg::ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          status_nxt = sia_pkg::ST_BADIDX;
        end else begin
          cmd_nxt.era = 1'b1;
          rden_nxt    = 1'b1;
          newcnt_nxt  = count_r - CW'(1);
        end
      end
      sia_pkg::OP_GET: begin
        if (count_r == '0) begin
          status_nxt = sia_pkg::ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          status_nxt = sia_pkg::ST_BADIDX;
        end else begin
          rden_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sia_pkg::S_IDLE: if (accept) state_nxt = sia_pkg::S_READ;
      sia_pkg::S_READ: state_nxt = sia_pkg::S_EXEC;
      sia_pkg::S_EXEC: if (fire) state_nxt = sia_pkg::S_IDLE;
      default:         state_nxt = sia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    tree_en  = 1'b0;
    fire     = 1'b0;
    unique case (state_r)
      sia_pkg::S_IDLE: in_stall = 1'b0;
      sia_pkg::S_READ: tree_en  = 1'b1;
      sia_pkg::S_EXEC: fire     = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sia_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmd_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cmd_r <= cmd_nxt;
      end
      if (fire) begin
        count_r     <= newcnt_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r   <= addr_nxt;
      val_r    <= val_ext[WORD_WIDTH-1:0];
      rden_r   <= rden_nxt;
      status_r <= status_nxt;
      newcnt_r <= newcnt_nxt;
    end
    if (fire) begin
      out_word_r.read_value <= rden_r ? rd_ext[31:0] : 32'd0;
      out_word_r.count      <= cnt_ext[6:0];
      out_word_r.status     <= status_r;
    end
  end

  assign rd_ext  = 64'(rd_word);
  assign cnt_ext = 16'(newcnt_r);

  assign cell_cmd.ins = cmd_r.ins && fire;
  assign cell_cmd.era = cmd_r.era && fire;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    sia_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW),
      .POS        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .addr       (addr_r),
      .din        (val_r),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  sia_rd_tree #(
    .WORD_WIDTH (WORD_WIDTH),
    .DEPTH      (DEPTH)
  ) u_rd_tree (
    .clk     (clk),
    .en      (tree_en),
    .words   (cell_rd),
    .rd_word (rd_word)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above capacity");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sia_pkg::S_READ)
    else $error("accept did not start a read");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status_r != sia_pkg::ST_OK) |=> count_r == $past(count_r))
    else $error("failed operation changed the count");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sia_pkg::S_EXEC)
    else $error("result without execute");

  a_shift_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_r.ins && cmd_r.era))
    else $error("insert and erase together");

endmodule

`default_nettype wire

FILE: test/sia_result_check.sv
module sia_result_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sia_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sia_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending,
  output int                 compared,
  output int                 full_hits,
  output int                 empty_hits,
  output int                 badidx_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]        shadow_entries [sia_pkg::DEPTH_DEF];
  logic [6:0]         shadow_count;
  sia_pkg::out_word_t expected_words [$];

  function automatic sia_pkg::out_word_t array_op_result(sia_pkg::in_word_t w);
    sia_pkg::out_word_t r;
    r = '0;
    r.status = sia_pkg::ST_OK;
    case (w.opcode)
      sia_pkg::OP_PUSH: begin
        if (shadow_count == sia_pkg::DEPTH_DEF) begin
          r.status = sia_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_count[5:0]] = w.value;
          shadow_count++;
        end
      end
      sia_pkg::OP_POP: begin
        if (shadow_count == 0) begin
          r.status = sia_pkg::ST_EMPTY;
        end else begin
          shadow_count--;
          r.read_value = shadow_entries[shadow_count[5:0]];
        end
      end
      sia_pkg::OP_INSERT: begin
        if (shadow_count == sia_pkg::DEPTH_DEF) begin
          r.status = sia_pkg::ST_FULL;
        end else if (w.index > shadow_count) begin
          r.status = sia_pkg::ST_BADIDX;
        end else begin
          for (int i = sia_pkg::DEPTH_DEF - 1; i > 0; i--)
            if (i > w.index && i <= shadow_count) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[w.index] = w.value;
          shadow_count++;
        end
      end
      sia_pkg::OP_ERASE: begin
        if (shadow_count == 0) begin
          r.status = sia_pkg::ST_EMPTY;
        end else if (w.index >= shadow_count) begin
          r.status = sia_pkg::ST_BADIDX;
        end else begin
          r.read_value = shadow_entries[w.index];
          for (int i = 0; i < sia_pkg::DEPTH_DEF - 1; i++)
            if (i >= w.index && i + 1 < shadow_count) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      sia_pkg::OP_GET: begin
        if (shadow_count == 0) begin
          r.status = sia_pkg::ST_EMPTY;
        end else if (w.index >= shadow_count) begin
          r.status = sia_pkg::ST_BADIDX;
        end else begin
          r.read_value = shadow_entries[w.index];
        end
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  always @(posedge clk) begin
    sia_pkg::out_word_t exp_word;
    sia_pkg::out_word_t exp_next;
    if (!rst_n) begin
      shadow_count = '0;
      expected_words.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %p", out_word);
          fail_count++;
        end else begin
          exp_word = expected_words.pop_front();
          compared++;
          if (out_word.read_value !== exp_word.read_value) begin
            $error("read_value: expected %h, got %h", exp_word.read_value, out_word.read_value);
            fail_count++;
          end
          if (out_word.count !== exp_word.count) begin
            $error("count: expected %0d, got %0d", exp_word.count, out_word.count);
            fail_count++;
          end
          if (out_word.status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, out_word.status);
            fail_count++;
          end
          case (exp_word.status)
            sia_pkg::ST_FULL:   full_hits++;
            sia_pkg::ST_EMPTY:  empty_hits++;
            sia_pkg::ST_BADIDX: badidx_hits++;
            default: ;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        exp_next = array_op_result(in_word);
        expected_words = {expected_words, exp_next};
      end
      pending <= expected_words.size();
    end
  end

endmodule

FILE: test/tb_shift_insert_array.sv
module tb_shift_insert_array;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;

  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sia_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sia_pkg::out_word_t out_word;

  int   fail_count;
  int   pending;
  int   compared;
  int   full_hits;
  int   empty_hits;
  int   badidx_hits;
  int   cycle_count = 0;
  int   sent = 0;
  int   level = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  shift_insert_array dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  sia_result_check array_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared),
    .full_hits  (full_hits),
    .empty_hits (empty_hits),
    .badidx_hits(badidx_hits)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_shift_insert_array failed");
      $finish;
    end
  end

  // hold off the output once for a long stretch so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 15);
    end
  end

  task automatic issue(input logic [2:0] op, input logic [5:0] idx, input logic [31:0] val);
    sia_pkg::in_word_t w;
    int                gap;
    w.opcode = op;
    w.index  = idx;
    w.value  = val;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    case (op)
      sia_pkg::OP_PUSH:   if (level < sia_pkg::DEPTH_DEF) level++;
      sia_pkg::OP_POP:    if (level > 0) level--;
      sia_pkg::OP_INSERT: if (level < sia_pkg::DEPTH_DEF && idx <= level) level++;
      sia_pkg::OP_ERASE:  if (level > 0 && idx < level) level--;
      default: ;
    endcase
  endtask

  task automatic random_word(input int add_pct, input int rem_pct);
    int          r;
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end else if (r < 3 + add_pct) begin
      op = $urandom_range(0, 1) ? sia_pkg::OP_INSERT : sia_pkg::OP_PUSH;
    end else if (r < 3 + add_pct + rem_pct) begin
      op = $urandom_range(0, 1) ? sia_pkg::OP_ERASE : sia_pkg::OP_POP;
    end else begin
      op = sia_pkg::OP_GET;
    end
    if ($urandom_range(0, 99) < 20) idx = 6'($urandom_range(0, 63));
    else if (op == sia_pkg::OP_INSERT) idx = 6'((level > 63) ? 63 : $urandom_range(0, level));
    else idx = 6'((level == 0) ? 0 : $urandom_range(0, level - 1));
    r = $urandom_range(0, 9);
    val = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    issue(op, idx, val);
  endtask

  initial begin
    int add_pct;
    int rem_pct;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(sia_pkg::OP_POP,    6'd0,  32'h1234_5678);
    issue(sia_pkg::OP_ERASE,  6'd0,  32'h0);
    issue(sia_pkg::OP_GET,    6'd63, 32'h0);
    issue(sia_pkg::OP_INSERT, 6'd1,  32'hDEAD_BEEF);
    issue(sia_pkg::OP_INSERT, 6'd0,  32'hFFFF_FFFF);
    issue(sia_pkg::OP_PUSH,   6'd63, 32'h0);
    issue(sia_pkg::OP_INSERT, 6'd2,  32'hA5A5_A5A5);
    issue(sia_pkg::OP_INSERT, 6'd1,  32'h5A5A_5A5A);
    issue(sia_pkg::OP_GET,    6'd0,  32'h0);
    issue(sia_pkg::OP_GET,    6'd1,  32'h0);
    issue(sia_pkg::OP_GET,    6'd4,  32'h0);
    issue(sia_pkg::OP_GET,    6'd3,  32'h0);
    issue(sia_pkg::OP_ERASE,  6'd1,  32'h0);
    issue(sia_pkg::OP_ERASE,  6'd2,  32'h0);
    issue(sia_pkg::OP_ERASE,  6'd5,  32'h0);
    issue(sia_pkg::OP_INSERT, 6'd63, 32'h0);
    issue(OP_UNUSED_LO,       6'd63, 32'hFFFF_FFFF);
    issue(OP_UNUSED_MID,      6'd0,  32'h0);
    issue(OP_UNUSED_HI,       6'd42, 32'h8000_0001);
    issue(sia_pkg::OP_POP,    6'd0,  32'h0);
    issue(sia_pkg::OP_POP,    6'd0,  32'h0);
    issue(sia_pkg::OP_POP,    6'd0,  32'h0);

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0, 2:    begin add_pct = 65; rem_pct = 17; end
        1, 4:    begin add_pct = 17; rem_pct = 65; end
        default: begin add_pct = 40; rem_pct = 40; end
      endcase
      no_idle <= (blk == 3);
      if (blk == 2) hold_req <= 1'b1;
      repeat (150) random_word(add_pct, rem_pct);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("%0d words sent, %0d results compared in %0d cycles", sent, compared, cycle_count);
    $display("failures seen: full %0d, empty %0d, bad index %0d",
             full_hits, empty_hits, badidx_hits);
    if (fail_count == 0) begin
      $display("tb_shift_insert_array passed");
    end else begin
      $display("tb_shift_insert_array failed");
    end
    $finish;
  end

endmodule
